@@ sv/sgsc_pkg.sv @@
package sgsc_pkg;

	// Angles are in 1/16 degree.
	localparam int FULL_TURN    = 5760;
	localparam int QUARTER_TURN = 1440;
	localparam int TABLE_STEP   = 48;
	localparam int TABLE_LAST   = 30;

	// The raw phase sum is biased so that it is never negative and stays below 16 turns.
	localparam int PHASE_BIAS = 6 * FULL_TURN;
	localparam int PHASE_W    = 17;

	// Two entries between the front and the back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_AMP_VERTICAL, REG_AMP_HORIZONTAL, REG_PHASE_STEP_VERTICAL,
		REG_PHASE_STEP_HORIZONTAL, REG_PHASE_VERT_HORIZ, REG_OFFSET_HORIZONTAL,
		REG_INITIAL_PHASE, REG_GAIN
	} cfg_reg_t;

	typedef struct packed {
		logic        [11:0] amp_vertical;
		logic        [11:0] amp_horizontal;
		logic signed [13:0] phase_step_vertical;
		logic signed [13:0] phase_step_horizontal;
		logic signed [13:0] phase_vert_horiz;
		logic signed [13:0] offset_horizontal;
		logic        [12:0] initial_phase;
		logic        [15:0] gain;
	} cfg_t;

	// One joint item, classified by the front.
	typedef struct packed {
		logic signed [12:0] angle;
		logic        [2:0]  joint;
		logic               odd;
		logic        [1:0]  pair;
		logic               counted;
		logic               last;
	} job_t;

	typedef struct packed {
		logic valid;
		job_t job;
	} head_t;

	// Quarter wave of sine in Q1.15, one entry every 3 degrees.
	function automatic logic [14:0] sine_entry(input logic [4:0] idx);
		logic [14:0] v;
		unique case (idx)
			5'd0:  v = 15'd0;
			5'd1:  v = 15'd1715;
			5'd2:  v = 15'd3425;
			5'd3:  v = 15'd5126;
			5'd4:  v = 15'd6813;
			5'd5:  v = 15'd8481;
			5'd6:  v = 15'd10126;
			5'd7:  v = 15'd11743;
			5'd8:  v = 15'd13328;
			5'd9:  v = 15'd14876;
			5'd10: v = 15'd16384;
			5'd11: v = 15'd17846;
			5'd12: v = 15'd19260;
			5'd13: v = 15'd20621;
			5'd14: v = 15'd21925;
			5'd15: v = 15'd23170;
			5'd16: v = 15'd24351;
			5'd17: v = 15'd25465;
			5'd18: v = 15'd26509;
			5'd19: v = 15'd27481;
			5'd20: v = 15'd28377;
			5'd21: v = 15'd29196;
			5'd22: v = 15'd29934;
			5'd23: v = 15'd30591;
			5'd24: v = 15'd31163;
			5'd25: v = 15'd31651;
			5'd26: v = 15'd32051;
			5'd27: v = 15'd32364;
			5'd28: v = 15'd32587;
			5'd29: v = 15'd32722;
			default: v = 15'd32767;
		endcase
		return v;
	endfunction

endpackage

@@ sv/sgsc_front.sv @@
module sgsc_front #(
	parameter int JOINTS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [15:0]          s_tdata,
	input  logic                 pop,
	output sgsc_pkg::head_t      head
);

	sgsc_pkg::job_t                           entry_q [sgsc_pkg::QUEUE_DEPTH];
	logic [sgsc_pkg::QUEUE_PTR_W-1:0]         wr_ptr_q;
	logic [sgsc_pkg::QUEUE_PTR_W-1:0]         rd_ptr_q;
	logic [sgsc_pkg::QUEUE_CNT_W-1:0]         count_q;
	sgsc_pkg::job_t                           job_c;
	logic                                     push;

	// Classify the joint: wave selection, pair number, and its role in the pass.
	always_comb begin
		job_c.angle   = $signed(s_tdata[12:0]);
		job_c.joint   = s_tdata[15:13];
		job_c.odd     = s_tdata[13];
		job_c.pair    = s_tdata[15:14];
		job_c.counted = 32'(s_tdata[15:13]) < JOINTS;
		job_c.last    = 32'(s_tdata[15:13]) == JOINTS - 1;
	end

	assign s_tready   = count_q != sgsc_pkg::QUEUE_CNT_W'(sgsc_pkg::QUEUE_DEPTH);
	assign push       = s_tvalid && s_tready;
	assign head.valid = count_q != '0;
	assign head.job   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= job_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTH
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("queue popped while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= sgsc_pkg::QUEUE_CNT_W'(sgsc_pkg::QUEUE_DEPTH))
		else $error("queue count beyond depth");
`endif

endmodule

@@ sv/sgsc_back.sv @@
module sgsc_back #(
	parameter int JOINTS           = 8,
	parameter int SAMPLES          = 32,
	parameter int MAX_VELOCITY     = 4096,
	parameter int STABLE_TOLERANCE = 80
) (
	input  logic             clk,
	input  logic             arst_n,
	input  sgsc_pkg::cfg_t   cfg,
	input  sgsc_pkg::head_t  head,
	output logic             pop,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [23:0]      m_tdata
);

	localparam int SIDX_W     = $clog2(SAMPLES);
	localparam int BASE_Q     = sgsc_pkg::FULL_TURN / SAMPLES;
	localparam int BASE_R     = sgsc_pkg::FULL_TURN % SAMPLES;
	localparam int BASE_RESET = (sgsc_pkg::FULL_TURN * (SAMPLES - 1)) / SAMPLES;
	localparam int REM_RESET  = (sgsc_pkg::FULL_TURN * (SAMPLES - 1)) % SAMPLES;
	localparam int PW         = sgsc_pkg::PHASE_W;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SUM, ST_RED, ST_QUAD, ST_IDX, ST_INTERP, ST_DIV,
		ST_SCALE, ST_ERR, ST_VEL, ST_DONE
	} state_t;

	state_t              state_q;
	sgsc_pkg::job_t      job_q;
	// Sample whose references are in use, and floor(FULL_TURN*m/SAMPLES) kept incrementally.
	logic [SIDX_W-1:0]   m_q;
	logic [12:0]         base_q;
	logic [SIDX_W-1:0]   rem_q;
	logic                loaded_q;
	logic [3:0]          stable_q;
	logic [PW-1:0]       phase_q;
	logic [1:0]          red_q;
	logic [10:0]         rr_q;
	logic                neg_q;
	logic [4:0]          idx_q;
	logic [5:0]          frac_q;
	logic [14:0]         lo_q;
	logic [20:0]         prod_q;
	logic                top_q;
	logic [14:0]         mag_q;
	logic [11:0]         sc_q;
	logic signed [15:0]  err_q;
	logic [30:0]         velp_q;
	logic                near_q;
	logic                negv_q;
	logic                out_valid_q;
	logic [23:0]         out_data_q;

	logic signed [13:0]  step_c;
	logic signed [16:0]  step_mul_c;
	logic signed [13:0]  vh_c;
	logic signed [18:0]  sum_c;
	logic [PW-1:0]       sub_c;
	logic [1:0]          quad_c;
	logic [10:0]         r_c;
	logic [10:0]         rr_c;
	logic [13:0]         div3_c;
	logic [4:0]          idx_c;
	logic [10:0]         idx48_c;
	logic [14:0]         lo_c;
	logic [14:0]         hi_c;
	logic [14:0]         diff_c;
	logic [29:0]         recip_c;
	logic [14:0]         mag_c;
	logic [11:0]         amp_c;
	logic [26:0]         sp_c;
	logic signed [13:0]  sc_s_c;
	logic signed [14:0]  ref_c;
	logic [15:0]         abs_c;
	logic [14:0]         errm_c;
	logic [22:0]         vm_c;
	logic [15:0]         v16_c;
	logic [15:0]         vel_c;
	logic [4:0]          total_c;
	logic                adv_c;
	logic [SIDX_W:0]     rem_sum_c;
	logic                out_free;

	always_comb begin
		// Raw phase sum, biased to stay non-negative.
		step_c     = job_q.odd ? cfg.phase_step_horizontal : cfg.phase_step_vertical;
		step_mul_c = 17'(step_c) * 17'($signed({1'b0, job_q.pair}));
		vh_c       = job_q.odd ? cfg.phase_vert_horiz : 14'sd0;
		sum_c      = 19'($signed({1'b0, base_q})) + 19'($signed({1'b0, cfg.initial_phase}))
		           + 19'(step_mul_c) + 19'(vh_c) + 19'(sgsc_pkg::PHASE_BIAS);

		// Binary reduction: subtract 8, 4, 2 and 1 turns where they fit.
		sub_c = PW'(sgsc_pkg::FULL_TURN) << red_q;

		// Quadrant and mirror into the first quarter.
		if (phase_q >= PW'(3 * sgsc_pkg::QUARTER_TURN)) begin
			quad_c = 2'd3;
		end else if (phase_q >= PW'(2 * sgsc_pkg::QUARTER_TURN)) begin
			quad_c = 2'd2;
		end else if (phase_q >= PW'(sgsc_pkg::QUARTER_TURN)) begin
			quad_c = 2'd1;
		end else begin
			quad_c = 2'd0;
		end
		r_c  = 11'(phase_q - PW'(quad_c) * PW'(sgsc_pkg::QUARTER_TURN));
		rr_c = quad_c[0] ? 11'(sgsc_pkg::QUARTER_TURN) - r_c : r_c;

		// Table index is rr/48: a shift by four, then a divide by three through 43/128.
		div3_c  = 14'(rr_q[10:4]) * 14'd43;
		idx_c   = div3_c[11:7];
		idx48_c = 11'({idx_c, 5'b0}) + 11'({idx_c, 4'b0});

		lo_c   = sgsc_pkg::sine_entry(idx_q);
		hi_c   = sgsc_pkg::sine_entry(idx_q + 5'd1);
		diff_c = hi_c - lo_c;

		// (diff*frac + 24)/48: shift by four, then divide by three through 2731/8192.
		recip_c = 30'(prod_q[20:4]) * 30'd2731;
		mag_c   = top_q ? 15'd32767 : lo_q + recip_c[27:13];

		amp_c = job_q.odd ? cfg.amp_horizontal : cfg.amp_vertical;
		sp_c  = 27'(amp_c) * 27'(mag_q);

		sc_s_c = neg_q ? -$signed({2'b0, sc_q}) : $signed({2'b0, sc_q});
		if (!loaded_q) begin
			ref_c = 15'sd0;
		end else if (job_q.odd) begin
			ref_c = 15'(sc_s_c) + 15'(cfg.offset_horizontal);
		end else begin
			ref_c = 15'(sc_s_c);
		end

		abs_c  = err_q[15] ? 16'(-err_q) : 16'(err_q);
		errm_c = abs_c[14:0];

		vm_c = 23'((velp_q + 31'd128) >> 8);
		if (vm_c > 23'(MAX_VELOCITY)) begin
			vm_c = 23'(MAX_VELOCITY);
		end
		v16_c = vm_c[15:0];
		vel_c = negv_q ? -v16_c : v16_c;

		total_c   = 5'(stable_q) + 5'(near_q);
		adv_c     = job_q.counted && job_q.last && (total_c >= 5'(JOINTS));
		rem_sum_c = (SIDX_W + 1)'(rem_q) + (SIDX_W + 1)'(BASE_R);
	end

	assign out_free = !out_valid_q || m_tready;
	assign pop      = (state_q == ST_IDLE) && head.valid;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			m_q         <= SIDX_W'(SAMPLES - 1);
			base_q      <= 13'(BASE_RESET);
			rem_q       <= SIDX_W'(REM_RESET);
			loaded_q    <= 1'b0;
			stable_q    <= '0;
			out_valid_q <= 1'b0;
			red_q       <= '0;
		end else begin
			// A new result replaces the one leaving; otherwise an accepted one clears.
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (head.valid) begin
						job_q   <= head.job;
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					phase_q <= sum_c[PW-1:0];
					red_q   <= 2'd3;
					state_q <= ST_RED;
				end
				ST_RED: begin
					if (phase_q >= sub_c) begin
						phase_q <= phase_q - sub_c;
					end
					red_q <= red_q - 2'd1;
					if (red_q == 2'd0) begin
						state_q <= ST_QUAD;
					end
				end
				ST_QUAD: begin
					rr_q    <= rr_c;
					neg_q   <= quad_c[1];
					state_q <= ST_IDX;
				end
				ST_IDX: begin
					idx_q   <= idx_c;
					frac_q  <= 6'(rr_q - idx48_c);
					state_q <= ST_INTERP;
				end
				ST_INTERP: begin
					lo_q    <= lo_c;
					prod_q  <= 21'(diff_c) * 21'(frac_q) + 21'(sgsc_pkg::TABLE_STEP / 2);
					top_q   <= idx_q >= 5'(sgsc_pkg::TABLE_LAST);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					mag_q   <= mag_c;
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					sc_q    <= 12'((sp_c + 27'd16384) >> 15);
					state_q <= ST_ERR;
				end
				ST_ERR: begin
					err_q   <= 16'($signed(job_q.angle)) - 16'(ref_c);
					state_q <= ST_VEL;
				end
				ST_VEL: begin
					velp_q  <= 31'(errm_c) * 31'(cfg.gain);
					near_q  <= 16'(errm_c) < 16'(STABLE_TOLERANCE);
					negv_q  <= !err_q[15] && (err_q != 16'sd0);
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_data_q  <= {3'b0, adv_c, near_q, job_q.joint, vel_c};
						if (job_q.counted) begin
							if (job_q.last) begin
								stable_q <= '0;
							end else begin
								stable_q <= (total_c > 5'd15) ? 4'd15 : total_c[3:0];
							end
						end
						if (adv_c) begin
							loaded_q <= 1'b1;
							if (m_q == SIDX_W'(SAMPLES - 1)) begin
								m_q    <= '0;
								base_q <= '0;
								rem_q  <= '0;
							end else begin
								m_q <= m_q + 1'b1;
								if (rem_sum_c >= (SIDX_W + 1)'(SAMPLES)) begin
									rem_q  <= SIDX_W'(rem_sum_c - (SIDX_W + 1)'(SAMPLES));
									base_q <= base_q + 13'(BASE_Q + 1);
								end else begin
									rem_q  <= rem_sum_c[SIDX_W-1:0];
									base_q <= base_q + 13'(BASE_Q);
								end
							end
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_sample_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(m_q) <= SAMPLES - 1)
		else $error("sample index out of range");
	a_phase_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_QUAD |-> phase_q < PW'(sgsc_pkg::FULL_TURN))
		else $error("phase not reduced below a full turn");
	a_first_advance: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(loaded_q) |-> m_q == '0)
		else $error("first advance did not land on sample zero");
`endif

endmodule

@@ sv/sine_gait_servo_controller.sv @@
// Sinusoidal gait generator with a proportional servo loop. Each request on the
// slave stream carries one measured joint angle and its joint number; the block
// answers one request on the master stream with a velocity command, the joint
// number, a near-reference flag and a flag telling that this joint closed a stable
// pass and moved the gait to its next sample. Even joints follow the vertical wave,
// odd joints the horizontal wave with its phase shift and offset; until the first
// advance every reference reads as zero. The front accepts and classifies joints
// into a two-entry queue, so until the queue is full it keeps taking requests while
// the back works or while a finished result waits at the output. The back handles
// one joint at a time with a sequencer: phase sum, four reduction steps, quadrant,
// table index, sine interpolation, amplitude scaling, error and gain. The user must
// write the configuration registers through cfg_we, cfg_index and cfg_data only
// while no joint is in flight; the block itself does not enforce this.
module sine_gait_servo_controller #(
	parameter int JOINTS           = 8,
	parameter int SAMPLES          = 32,
	parameter int MAX_VELOCITY     = 4096,
	parameter int STABLE_TOLERANCE = 80
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // joint_angle[12:0], joint_index[15:13]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // velocity[15:0], joint_out[18:16],
	                               // near_reference[19], sequence_advanced[20], zero fill
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	sgsc_pkg::cfg_t  cfg_q;
	sgsc_pkg::head_t head;
	logic            pop;

	// Register file. Gain resets to unity in Q8.8, everything else to zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.amp_vertical          <= '0;
			cfg_q.amp_horizontal        <= '0;
			cfg_q.phase_step_vertical   <= '0;
			cfg_q.phase_step_horizontal <= '0;
			cfg_q.phase_vert_horiz      <= '0;
			cfg_q.offset_horizontal     <= '0;
			cfg_q.initial_phase         <= '0;
			cfg_q.gain                  <= 16'd256;
		end else if (cfg_we) begin
			unique case (sgsc_pkg::cfg_reg_t'(cfg_index))
				sgsc_pkg::REG_AMP_VERTICAL: begin
					cfg_q.amp_vertical <= cfg_data[11:0];
				end
				sgsc_pkg::REG_AMP_HORIZONTAL: begin
					cfg_q.amp_horizontal <= cfg_data[11:0];
				end
				sgsc_pkg::REG_PHASE_STEP_VERTICAL: begin
					cfg_q.phase_step_vertical <= $signed(cfg_data[13:0]);
				end
				sgsc_pkg::REG_PHASE_STEP_HORIZONTAL: begin
					cfg_q.phase_step_horizontal <= $signed(cfg_data[13:0]);
				end
				sgsc_pkg::REG_PHASE_VERT_HORIZ: begin
					cfg_q.phase_vert_horiz <= $signed(cfg_data[13:0]);
				end
				sgsc_pkg::REG_OFFSET_HORIZONTAL: begin
					cfg_q.offset_horizontal <= $signed(cfg_data[13:0]);
				end
				sgsc_pkg::REG_INITIAL_PHASE: begin
					cfg_q.initial_phase <= cfg_data[12:0];
				end
				sgsc_pkg::REG_GAIN: begin
					cfg_q.gain <= cfg_data;
				end
				default: ;
			endcase
		end
	end

	// Front: takes requests and classifies each joint into the queue.
	sgsc_front #(
		.JOINTS(JOINTS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.pop      (pop),
		.head     (head)
	);

	// Back: reference, error and velocity, plus the pass bookkeeping.
	sgsc_back #(
		.JOINTS           (JOINTS),
		.SAMPLES          (SAMPLES),
		.MAX_VELOCITY     (MAX_VELOCITY),
		.STABLE_TOLERANCE (STABLE_TOLERANCE)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

@@ sim/sine_gait_servo_controller_test.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the gait generator and joint servo. A driver process sends joint
// requests, keeps a behavioral copy of the controller and queues the command that each
// accepted request should produce. A receiver process stalls the master side at random
// and compares each command it takes, field by field, with the oldest queued one.
module sine_gait_servo_controller_test;

	localparam int JOINTS           = 8;
	localparam int SAMPLES          = 32;
	localparam int MAX_VELOCITY     = 4096;
	localparam int STABLE_TOLERANCE = 80;

	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 128;
	localparam int SETTLE      = 40;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PROBES      = 26;

	// One velocity command as the master side should deliver it.
	typedef struct packed {
		logic signed [15:0] velocity;
		logic        [2:0]  joint;
		logic               near;
		logic               advanced;
	} servo_cmd_t;

	// One row of the directed part. Where known is set, the command is typed in here;
	// otherwise it comes from the behavioral copy.
	typedef struct packed {
		logic signed [12:0] angle;
		logic        [2:0]  joint;
		logic               known;
		logic signed [15:0] velocity;
		logic               near;
		logic               advanced;
	} probe_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;     // joint_angle[12:0], joint_index[15:13]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;          // velocity[15:0], joint_out[18:16],
	                               // near_reference[19], sequence_advanced[20], zero fill
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// Commands still owed by the controller, oldest first.
	servo_cmd_t pending_cmds[$];
	int error_count = 0;
	int cycle_count = 0;
	int stall_left = 0;
	// While calm is set neither side inserts idle cycles.
	bit calm = 1'b0;
	int setting [8];

	// Behavioral copy of the register file and of the gait state.
	int amp_vert, amp_horiz, step_vert, step_horiz, shift_vh, offset_horiz, start_phase;
	int gain_q8;
	int sample_pos;
	bit refs_live;
	int stable_tally;

	// Quarter sine wave in Q1.15, one entry every 3 degrees.
	int quarter_wave [31] = '{
		0, 1715, 3425, 5126, 6813, 8481, 10126, 11743, 13328, 14876,
		16384, 17846, 19260, 20621, 21925, 23170, 24351, 25465, 26509, 27481,
		28377, 29196, 29934, 30591, 31163, 31651, 32051, 32364, 32587, 32722,
		32767
	};

	// The directed part. Before the first advance every reference reads as zero, so
	// with unity gain the velocity is simply the negated angle. The out of order rows
	// push the stable count past its ceiling of 15; a counter that wrapped would miss
	// the advance on the far joint 7 that follows them.
	probe_t probes [PROBES] = '{
		'{13'sd0,     3'd0, 1'b1, 16'sd0,     1'b1, 1'b0},
		'{13'sd0,     3'd1, 1'b1, 16'sd0,     1'b1, 1'b0},  // offset not applied yet
		'{13'sd4095,  3'd2, 1'b1, -16'sd4095, 1'b0, 1'b0},
		'{13'h1000,   3'd3, 1'b1, 16'sd4096,  1'b0, 1'b0},  // most negative angle
		'{13'sd79,    3'd4, 1'b1, -16'sd79,   1'b1, 1'b0},
		'{-13'sd80,   3'd5, 1'b1, 16'sd80,    1'b0, 1'b0},
		'{-13'sd79,   3'd6, 1'b1, 16'sd79,    1'b1, 1'b0},
		'{13'sd80,    3'd7, 1'b1, -16'sd80,   1'b0, 1'b0},  // only four stable joints
		'{13'sd1,     3'd6, 1'b1, -16'sd1,    1'b1, 1'b0},
		'{-13'sd1,    3'd5, 1'b1, 16'sd1,     1'b1, 1'b0},
		'{13'sd2,     3'd4, 1'b1, -16'sd2,    1'b1, 1'b0},
		'{-13'sd2,    3'd3, 1'b1, 16'sd2,     1'b1, 1'b0},
		'{13'sd3,     3'd2, 1'b1, -16'sd3,    1'b1, 1'b0},
		'{-13'sd3,    3'd1, 1'b1, 16'sd3,     1'b1, 1'b0},
		'{13'sd10,    3'd0, 1'b1, -16'sd10,   1'b1, 1'b0},
		'{-13'sd10,   3'd6, 1'b1, 16'sd10,    1'b1, 1'b0},
		'{13'sd20,    3'd5, 1'b1, -16'sd20,   1'b1, 1'b0},
		'{-13'sd20,   3'd4, 1'b1, 16'sd20,    1'b1, 1'b0},
		'{13'sd40,    3'd3, 1'b1, -16'sd40,   1'b1, 1'b0},
		'{-13'sd40,   3'd2, 1'b1, 16'sd40,    1'b1, 1'b0},
		'{13'sd60,    3'd1, 1'b1, -16'sd60,   1'b1, 1'b0},
		'{-13'sd60,   3'd0, 1'b1, 16'sd60,    1'b1, 1'b0},
		'{13'sd78,    3'd6, 1'b1, -16'sd78,   1'b1, 1'b0},
		'{-13'sd78,   3'd5, 1'b1, 16'sd78,    1'b1, 1'b0},
		'{13'sd2000,  3'd7, 1'b1, -16'sd2000, 1'b0, 1'b1},  // first advance
		'{13'sd300,   3'd1, 1'b0, 16'sd0,     1'b0, 1'b0}   // offset now applies
	};

	sine_gait_servo_controller #(
		.JOINTS(JOINTS),
		.SAMPLES(SAMPLES),
		.MAX_VELOCITY(MAX_VELOCITY),
		.STABLE_TOLERANCE(STABLE_TOLERANCE)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int idle_span();
		int roll;
		roll = $urandom_range(0, 99);
		if (calm || roll < 55)
			return 0;
		else if (roll < 90)
			return $urandom_range(1, 3);
		else if (roll < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Register writes keep only the bits that each register holds.
	function automatic void store_reg(input sgsc_pkg::cfg_reg_t sel, input logic [15:0] d);
		case (sel)
			sgsc_pkg::REG_AMP_VERTICAL:          amp_vert = d[11:0];
			sgsc_pkg::REG_AMP_HORIZONTAL:        amp_horiz = d[11:0];
			sgsc_pkg::REG_PHASE_STEP_VERTICAL:   step_vert = $signed(d[13:0]);
			sgsc_pkg::REG_PHASE_STEP_HORIZONTAL: step_horiz = $signed(d[13:0]);
			sgsc_pkg::REG_PHASE_VERT_HORIZ:      shift_vh = $signed(d[13:0]);
			sgsc_pkg::REG_OFFSET_HORIZONTAL:     offset_horiz = $signed(d[13:0]);
			sgsc_pkg::REG_INITIAL_PHASE:         start_phase = d[12:0];
			sgsc_pkg::REG_GAIN:                  gain_q8 = d;
			default: ;
		endcase
	endfunction

	// Sine in Q1.15 of a phase in 0 to FULL_TURN-1, interpolated between table entries
	// with rounding and mirrored into the other three quadrants.
	function automatic int wave_q15(input int p);
		int quad, rem, idx, frac, v;
		quad = p / sgsc_pkg::QUARTER_TURN;
		rem = p % sgsc_pkg::QUARTER_TURN;
		if (quad % 2 == 1)
			rem = sgsc_pkg::QUARTER_TURN - rem;
		idx = rem / sgsc_pkg::TABLE_STEP;
		frac = rem % sgsc_pkg::TABLE_STEP;
		if (idx >= sgsc_pkg::TABLE_LAST)
			v = quarter_wave[sgsc_pkg::TABLE_LAST];
		else
			v = quarter_wave[idx] + ((quarter_wave[idx + 1] - quarter_wave[idx]) * frac
				+ sgsc_pkg::TABLE_STEP / 2) / sgsc_pkg::TABLE_STEP;
		return (quad >= 2) ? -v : v;
	endfunction

	// Amplitude times a Q1.15 sine, rounded half away from zero.
	function automatic int scale_amplitude(input int amp, input int s);
		longint prod, mag;
		int r;
		prod = longint'(amp) * s;
		mag = (prod < 0) ? -prod : prod;
		r = int'((mag + 16384) >>> 15);
		return (prod < 0) ? -r : r;
	endfunction

	// Reference angle of a joint for the sample that is in use now.
	function automatic int joint_target(input int j);
		int m, ph;
		if (!refs_live)
			return 0;
		m = (sample_pos + SAMPLES - 1) % SAMPLES;
		ph = sgsc_pkg::FULL_TURN * m / SAMPLES + start_phase;
		if (j % 2 == 0) begin
			ph += step_vert * (j / 2);
			ph = ((ph % sgsc_pkg::FULL_TURN) + sgsc_pkg::FULL_TURN) % sgsc_pkg::FULL_TURN;
			return scale_amplitude(amp_vert, wave_q15(ph));
		end
		ph += step_horiz * (j / 2) + shift_vh;
		ph = ((ph % sgsc_pkg::FULL_TURN) + sgsc_pkg::FULL_TURN) % sgsc_pkg::FULL_TURN;
		return scale_amplitude(amp_horiz, wave_q15(ph)) + offset_horiz;
	endfunction

	// Command for one joint request; also moves the gait state on.
	function automatic servo_cmd_t servo_response(input logic signed [12:0] ang,
			input logic [2:0] jnt);
		longint err, prod, mag, vel;
		int total;
		servo_cmd_t c;
		err = ang - joint_target(jnt);
		prod = -err * gain_q8;
		mag = (prod < 0) ? -prod : prod;
		vel = (mag + 128) >>> 8;
		if (prod < 0)
			vel = -vel;
		if (vel > MAX_VELOCITY)
			vel = MAX_VELOCITY;
		if (vel < -MAX_VELOCITY)
			vel = -MAX_VELOCITY;
		c.velocity = vel[15:0];
		c.joint = jnt;
		c.near = ((err < 0) ? -err : err) < STABLE_TOLERANCE;
		c.advanced = 1'b0;
		total = stable_tally + c.near;
		if (int'(jnt) < JOINTS) begin
			if (int'(jnt) == JOINTS - 1) begin
				// The last joint closes the pass; the count starts over either way.
				if (total >= JOINTS) begin
					sample_pos = (sample_pos + 1) % SAMPLES;
					refs_live = 1'b1;
					c.advanced = 1'b1;
				end
				stable_tally = 0;
			end else begin
				stable_tally = (total > 15) ? 15 : total;
			end
		end
		return c;
	endfunction

	// Angle for a well-formed pass: the joint's reference plus noise that mostly keeps
	// it within tolerance, sometimes sits right at the tolerance edge and sometimes
	// misses by a wide margin.
	function automatic logic signed [12:0] aim_angle(input int j);
		int a, roll;
		roll = $urandom_range(0, 99);
		a = joint_target(j);
		if (roll < 85)
			a += int'($urandom_range(0, 2 * STABLE_TOLERANCE - 2)) - (STABLE_TOLERANCE - 1);
		else if (roll < 95)
			a += ($urandom_range(0, 1) ? 1 : -1) * (STABLE_TOLERANCE - $urandom_range(0, 1));
		else
			a += int'($urandom_range(0, 800)) - 400;
		if (a > 4095)
			a = 4095;
		if (a < -4096)
			a = -4096;
		return a[12:0];
	endfunction

	// Presents one request and returns at the edge where it is taken.
	task automatic offer(input logic signed [12:0] ang, input logic [2:0] jnt);
		int gap;
		gap = idle_span();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {jnt, ang};
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	task automatic issue(input logic signed [12:0] ang, input logic [2:0] jnt);
		offer(ang, jnt);
		pending_cmds.push_back(servo_response(ang, jnt));
	endtask

	// Holds the sender back until every owed command has come out, then lets the
	// block settle so that registers can be written while it is idle.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_cmds.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Writes all eight registers from setting, one per cycle.
	task automatic load_settings();
		for (int r = 0; r < 8; r++) begin
			cfg_we <= 1'b1;
			cfg_index <= r[2:0];
			cfg_data <= setting[r][15:0];
			store_reg(sgsc_pkg::cfg_reg_t'(r), setting[r][15:0]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic report(input string what, input int want, input int got);
		$display("%0t: %s expected %0d, got %0d", $time, what, want, got);
		error_count++;
	endtask

	task automatic check_command(input logic [23:0] word);
		servo_cmd_t want;
		if (pending_cmds.size() == 0) begin
			$display("%0t: command %h arrived with none expected", $time, word);
			error_count++;
		end else begin
			want = pending_cmds[0];
			pending_cmds.delete(0);
			if ($signed(word[15:0]) != want.velocity)
				report("velocity", want.velocity, $signed(word[15:0]));
			if (word[18:16] != want.joint)
				report("joint_out", want.joint, word[18:16]);
			if (word[19] != want.near)
				report("near_reference", want.near, word[19]);
			if (word[20] != want.advanced)
				report("sequence_advanced", want.advanced, word[20]);
		end
	endtask

	// Receiver: takes commands and stalls the master side at random.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			check_command(m_tdata);
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			m_tready <= 1'b1;
			stall_left = idle_span();
		end
	end

	// Watchdog: a run that hangs ends here.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	// Driver: reset, directed rows, then phases of random requests under new settings.
	initial begin
		int sent, pick, burst, stop;
		logic [31:0] noise;
		servo_cmd_t cmd;

		amp_vert = 0;
		amp_horiz = 0;
		step_vert = 0;
		step_horiz = 0;
		shift_vh = 0;
		offset_horiz = 0;
		start_phase = 0;
		gain_q8 = 256;
		sample_pos = 0;
		refs_live = 1'b0;
		stable_tally = 0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (4) @(posedge clk);

		// Unity gain keeps the directed velocities readable. The waves and the offset
		// are set already, yet they must stay hidden until the first advance.
		setting = '{2000, 1500, 720, -720, 1440, 300, 0, 256};
		load_settings();

		for (int i = 0; i < PROBES; i++) begin
			offer(probes[i].angle, probes[i].joint);
			cmd = servo_response(probes[i].angle, probes[i].joint);
			if (probes[i].known) begin
				cmd.velocity = probes[i].velocity;
				cmd.joint = probes[i].joint;
				cmd.near = probes[i].near;
				cmd.advanced = probes[i].advanced;
			end
			pending_cmds.push_back(cmd);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			case (ph)
				// Lower ends of every range, with zero gain.
				0: setting = '{0, 0, -5760, -5760, -5760, -5760, 0, 0};
				// Upper ends of every range, with the largest gain.
				1: setting = '{2880, 2880, 5760, 5760, 5760, 5760, 5759, 65535};
				// Full register widths, beyond the documented ranges.
				2: setting = '{65535, 4095, 16'h2000, 16'h1FFF, 16'h3FFF, 16'hE000, 65535, 1};
				default: begin
					setting[sgsc_pkg::REG_AMP_VERTICAL] = $urandom_range(0, 2880);
					setting[sgsc_pkg::REG_AMP_HORIZONTAL] = $urandom_range(0, 2880);
					setting[sgsc_pkg::REG_PHASE_STEP_VERTICAL] =
						int'($urandom_range(0, 11520)) - 5760;
					setting[sgsc_pkg::REG_PHASE_STEP_HORIZONTAL] =
						int'($urandom_range(0, 11520)) - 5760;
					setting[sgsc_pkg::REG_PHASE_VERT_HORIZ] =
						int'($urandom_range(0, 11520)) - 5760;
					// A small offset leaves the odd joints reachable, so passes can advance.
					setting[sgsc_pkg::REG_OFFSET_HORIZONTAL] =
						int'($urandom_range(0, 400)) - 200;
					setting[sgsc_pkg::REG_INITIAL_PHASE] = $urandom_range(0, 5759);
					case ($urandom_range(0, 3))
						0: setting[sgsc_pkg::REG_GAIN] = 256;
						1: setting[sgsc_pkg::REG_GAIN] = $urandom_range(0, 512);
						2: setting[sgsc_pkg::REG_GAIN] = $urandom_range(512, 4096);
						default: setting[sgsc_pkg::REG_GAIN] = $urandom_range(0, 65535);
					endcase
					// Now and then one register gets junk in its unused upper bits too.
					if ($urandom_range(0, 4) == 0)
						setting[$urandom_range(0, 7)] = $urandom_range(0, 65535);
				end
			endcase
			load_settings();
			calm = ($urandom_range(0, 3) == 0);

			sent = 0;
			while (sent < PHASE_ITEMS) begin
				pick = $urandom_range(0, 9);
				if (pick < 8) begin
					// A whole pass in joint order, aimed at the references.
					for (int j = 0; j < JOINTS; j++)
						issue(aim_angle(j), j[2:0]);
					sent += JOINTS;
				end else if (pick == 8) begin
					// Arbitrary joints and angles over the whole field range.
					burst = $urandom_range(1, 6);
					repeat (burst) begin
						noise = $urandom();
						issue(noise[12:0], noise[15:13]);
					end
					sent += burst;
				end else begin
					// A pass broken off before its last joint.
					stop = $urandom_range(0, JOINTS - 2);
					for (int j = 0; j <= stop; j++)
						issue(aim_angle(j), j[2:0]);
					sent += stop + 1;
				end
			end
		end

		drain();
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
